/* rtl/three_level_page_table_store_macros.svh */
`ifndef THREE_LEVEL_PAGE_TABLE_STORE_MACROS_SVH
`define THREE_LEVEL_PAGE_TABLE_STORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TLPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TLPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tlpt_pkg.sv */
`default_nettype none

package tlpt_pkg;

  localparam int IDX_W   = 9;
  localparam int SLOTS   = 512;
  localparam int PAGE_W  = 44;
  localparam int FLAG_W  = 8;
  localparam int ENTRY_W = PAGE_W + FLAG_W + 1;

  localparam logic OP_MAP       = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [38:0] virtual_address;
    logic [43:0] physical_page;
    logic [7:0]  page_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [55:0] physical_address;
    logic [7:0]  leaf_flags;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_L2,
    S_L1,
    S_L0,
    S_WR_L2,
    S_WR_L1,
    S_WR_LEAF,
    S_DONE
  } state_t;

  function automatic rsp_t make_rsp(logic [1:0] status, logic [55:0] pa, logic [7:0] flags);
    rsp_t r;
    r.status           = status;
    r.physical_address = pa;
    r.leaf_flags       = flags;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/three_level_page_table_store.sv */
// Three-level page table store with an Sv39-style walk.
// Request channel req_valid/req_ready/req carries one map or translate
// transaction; response channel rsp_valid/rsp_ready/rsp returns exactly one
// result for each. Tables of 512 entries live in one synchronous memory
// (one write port, one read port, registered read data); every level of
// a walk is one dependent read of that memory, every table link or leaf
// update is one write.
// A translate reads levels 2, 1 and 0 in turn; a map reads level 2 and,
// if that link exists, level 1, then writes each missing table link and
// the leaf; a miss or no-space answer ends the walk early. The request
// side is ready again in the cycle after the result is handed to the
// output register.
// Reset clears the control state and starts a clearing pass that walks all
// TABLE_COUNT*512 entries, one per cycle; req_ready stays low during it.
// A stalled receiver holds rsp; one further request may be accepted and
// walked meanwhile, and its result waits until the output register frees.
`default_nettype none

module three_level_page_table_store #(
  parameter int TABLE_COUNT = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tlpt_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tlpt_pkg::rsp_t  rsp
);

  import tlpt_pkg::*;

  localparam int TABLE_W = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int ADDR_W  = TABLE_W + IDX_W;
  localparam int DEPTH   = TABLE_COUNT * SLOTS;
  localparam int CNT_W   = $clog2(TABLE_COUNT + 1);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  state_t              state, state_next;
  req_t                item, item_next;
  logic [TABLE_W-1:0]  cur_table, cur_table_next;
  logic [CNT_W-1:0]    tiu, tiu_next;
  logic [ADDR_W-1:0]   clr_cnt, clr_cnt_next;
  rsp_t                res, res_next;

  logic                mem_we, mem_re, rsp_load;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0]  mem_wdata;

  logic                rd_valid, link_ok, need1_over, need2_over;
  logic [PAGE_W-1:0]   rd_page;
  logic [23:0]         rd_link;
  logic [IDX_W-1:0]    idx2, idx1, idx0;
  logic [ENTRY_W-1:0]  link_word;

  assign rd_valid   = rd_data[ENTRY_W-1];
  assign rd_page    = rd_data[PAGE_W+FLAG_W-1:FLAG_W];
  assign rd_link    = rd_data[FLAG_W+23:FLAG_W];
  assign link_ok    = rd_link < 24'(TABLE_COUNT);
  assign idx2       = item.virtual_address[38:30];
  assign idx1       = item.virtual_address[29:21];
  assign idx0       = item.virtual_address[20:12];
  assign need1_over = ({1'b0, tiu} + (CNT_W+1)'(1)) > (CNT_W+1)'(TABLE_COUNT);
  assign need2_over = ({1'b0, tiu} + (CNT_W+1)'(2)) > (CNT_W+1)'(TABLE_COUNT);
  assign link_word  = {1'b1, {(PAGE_W-CNT_W){1'b0}}, tiu, 8'h01};

  always_comb begin
    state_next     = state;
    item_next      = item;
    cur_table_next = cur_table;
    tiu_next       = tiu;
    clr_cnt_next   = clr_cnt;
    res_next       = res;
    mem_we         = 1'b0;
    mem_waddr      = clr_cnt;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = {cur_table, idx1};
    req_ready      = 1'b0;
    rsp_load       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          item_next      = req;
          cur_table_next = '0;
          mem_re         = 1'b1;
          mem_raddr      = {TABLE_W'(0), req.virtual_address[38:30]};
          state_next     = S_L2;
        end
      end
      S_L2: begin
        if (!rd_valid) begin
          if (item.operation == OP_TRANSLATE) begin
            res_next   = make_rsp(ST_NOT_MAPPED, '0, '0);
            state_next = S_DONE;
          end else if (need2_over) begin
            res_next   = make_rsp(ST_NO_SPACE, '0, '0);
            state_next = S_DONE;
          end else begin
            state_next = S_WR_L2;
          end
        end else if (!link_ok) begin
          res_next   = make_rsp(ST_NOT_MAPPED, '0, '0);
          state_next = S_DONE;
        end else begin
          cur_table_next = rd_link[TABLE_W-1:0];
          mem_re         = 1'b1;
          mem_raddr      = {rd_link[TABLE_W-1:0], idx1};
          state_next     = S_L1;
        end
      end
      S_L1: begin
        if (!rd_valid) begin
          if (item.operation == OP_TRANSLATE) begin
            res_next   = make_rsp(ST_NOT_MAPPED, '0, '0);
            state_next = S_DONE;
          end else if (need1_over) begin
            res_next   = make_rsp(ST_NO_SPACE, '0, '0);
            state_next = S_DONE;
          end else begin
            state_next = S_WR_L1;
          end
        end else if (!link_ok) begin
          res_next   = make_rsp(ST_NOT_MAPPED, '0, '0);
          state_next = S_DONE;
        end else begin
          cur_table_next = rd_link[TABLE_W-1:0];
          if (item.operation == OP_TRANSLATE) begin
            mem_re     = 1'b1;
            mem_raddr  = {rd_link[TABLE_W-1:0], idx0};
            state_next = S_L0;
          end else begin
            state_next = S_WR_LEAF;
          end
        end
      end
      S_L0: begin
        if (!rd_valid) begin
          res_next = make_rsp(ST_NOT_MAPPED, '0, '0);
        end else begin
          res_next = make_rsp(ST_OK, {rd_page, item.virtual_address[11:0]},
                              rd_data[FLAG_W-1:0]);
        end
        state_next = S_DONE;
      end
      S_WR_L2: begin
        mem_we         = 1'b1;
        mem_waddr      = {cur_table, idx2};
        mem_wdata      = link_word;
        cur_table_next = tiu[TABLE_W-1:0];
        tiu_next       = tiu + CNT_W'(1);
        state_next     = S_WR_L1;
      end
      S_WR_L1: begin
        mem_we         = 1'b1;
        mem_waddr      = {cur_table, idx1};
        mem_wdata      = link_word;
        cur_table_next = tiu[TABLE_W-1:0];
        tiu_next       = tiu + CNT_W'(1);
        state_next     = S_WR_LEAF;
      end
      S_WR_LEAF: begin
        mem_we     = 1'b1;
        mem_waddr  = {cur_table, idx0};
        mem_wdata  = {1'b1, item.physical_page, item.page_flags | 8'h01};
        res_next   = make_rsp(ST_OK, {item.physical_page, 12'h000},
                              item.page_flags | 8'h01);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      tiu     <= CNT_W'(1);
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      tiu     <= tiu_next;
    end
  end

  always_ff @(posedge clk) begin
    item      <= item_next;
    cur_table <= cur_table_next;
    res       <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/tlpt_checker.sv */
`default_nettype none

`include "three_level_page_table_store_macros.svh"

module tlpt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tlpt_pkg::rsp_t rsp
);

  import tlpt_pkg::*;

  `TLPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `TLPT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second request taken during a walk")
  `TLPT_ASSERT_SAME(a_status_code, rsp_valid, rsp.status == ST_OK || rsp.status == ST_NOT_MAPPED || rsp.status == ST_NO_SPACE, "bad status code")
  `TLPT_ASSERT_SAME(a_fail_zero, rsp_valid && rsp.status != ST_OK, rsp.physical_address == '0 && rsp.leaf_flags == '0, "failed transaction carries data")
  `TLPT_ASSERT_SAME(a_ok_flag, rsp_valid && rsp.status == ST_OK, rsp.leaf_flags[0], "ok result without valid flag")

endmodule

bind three_level_page_table_store tlpt_checker u_tlpt_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tlpt_pkg::*;

  localparam int TABLE_COUNT       = 16;
  localparam int STORE_DEPTH       = TABLE_COUNT * SLOTS;
  localparam int RANDOM_PER_PHASE  = 375;
  localparam int WATCHDOG_LIMIT    = 50000;
  localparam int DRAIN_CYCLES      = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // page table shadow
  logic [51:0] pt_entry [STORE_DEPTH];
  bit          pt_valid [STORE_DEPTH];
  int unsigned tables_used = 1;

  req_t        pending_reqs [$];
  rsp_t        expected_rsps [$];
  logic [38:0] mapped_vas [$];
  rsp_t        want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_translate = 0;
  int unsigned n_ok = 0;
  int unsigned n_unmapped = 0;
  int unsigned n_nospace = 0;

  three_level_page_table_store #(.TABLE_COUNT(TABLE_COUNT)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rsp_t walk_page_table(req_t r);
    rsp_t        res;
    logic [38:0] va;
    logic [7:0]  flg;
    logic [51:0] ent;
    int unsigned tbl;
    int unsigned slot;
    int unsigned need;
    int          lvl;
    res = '0;
    va  = r.virtual_address;
    flg = r.page_flags | 8'h01;
    tbl = 0;
    need = 0;
    ent = '0;
    if (r.operation == OP_TRANSLATE) begin
      for (lvl = 2; lvl >= 0; lvl--) begin
        slot = tbl * SLOTS + va[12 + 9 * lvl +: 9];
        if (!pt_valid[slot]) begin
          res.status = ST_NOT_MAPPED;
          return res;
        end
        ent = pt_entry[slot];
        if (lvl > 0) begin
          tbl = ent[31:8];
          if (tbl >= TABLE_COUNT) begin
            res.status = ST_NOT_MAPPED;
            return res;
          end
        end
      end
      res.status           = ST_OK;
      res.physical_address = {ent[51:8], va[11:0]};
      res.leaf_flags       = ent[7:0];
      return res;
    end
    // count tables to create before touching anything
    for (lvl = 2; lvl > 0; lvl--) begin
      slot = tbl * SLOTS + va[12 + 9 * lvl +: 9];
      if (!pt_valid[slot]) begin
        need = lvl;
        break;
      end
      tbl = pt_entry[slot][31:8];
      if (tbl >= TABLE_COUNT) begin
        res.status = ST_NOT_MAPPED;
        return res;
      end
    end
    if (tables_used + need > TABLE_COUNT) begin
      res.status = ST_NO_SPACE;
      return res;
    end
    tbl = 0;
    for (lvl = 2; lvl > 0; lvl--) begin
      slot = tbl * SLOTS + va[12 + 9 * lvl +: 9];
      if (!pt_valid[slot]) begin
        pt_entry[slot] = (52'(tables_used) << 8) | 52'h1;
        pt_valid[slot] = 1'b1;
        tbl = tables_used;
        tables_used++;
      end else begin
        tbl = pt_entry[slot][31:8];
      end
    end
    slot = tbl * SLOTS + va[20:12];
    pt_entry[slot] = {r.physical_page, flg};
    pt_valid[slot] = 1'b1;
    res.status           = ST_OK;
    res.physical_address = {r.physical_page, 12'h000};
    res.leaf_flags       = flg;
    return res;
  endfunction

  function automatic void queue_request(logic op, logic [38:0] va, logic [43:0] ppn,
                                        logic [7:0] flg);
    req_t r;
    r.operation       = op;
    r.virtual_address = va;
    r.physical_page   = ppn;
    r.page_flags      = flg;
    pending_reqs.push_back(r);
    if (op == OP_MAP) mapped_vas.push_back(va);
  endfunction

  // mostly walks into regions already built, rarely grows the table tree
  function automatic void queue_random_request();
    logic [38:0] base;
    logic [38:0] rva;
    logic [43:0] rppn;
    logic [7:0]  rflg;
    int unsigned pick;
    pick = $urandom_range(999);
    rva  = 39'({$urandom, $urandom});
    rppn = 44'({$urandom, $urandom});
    rflg = 8'($urandom);
    base = rva;
    if (mapped_vas.size() != 0) base = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
    if (mapped_vas.size() == 0 || pick < 5) queue_request(OP_MAP, rva, rppn, rflg);
    else if (pick < 15)  queue_request(OP_MAP, {base[38:30], rva[29:0]}, rppn, rflg);
    else if (pick < 300) queue_request(OP_MAP, {base[38:21], rva[20:0]}, rppn, rflg);
    else if (pick < 400) queue_request(OP_MAP, {base[38:12], rva[11:0]}, rppn, rflg);
    else if (pick < 750) queue_request(OP_TRANSLATE, {base[38:12], rva[11:0]}, rppn, rflg);
    else if (pick < 850) queue_request(OP_TRANSLATE, {base[38:21], rva[20:0]}, rppn, rflg);
    else if (pick < 900) queue_request(OP_TRANSLATE, {base[38:30], rva[29:0]}, rppn, rflg);
    else queue_request(OP_TRANSLATE, rva, rppn, rflg);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(walk_page_table(req));
        if (req.operation == OP_TRANSLATE) n_translate++;
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("response transaction with nothing outstanding: status %0d pa %h flags %h",
               rsp.status, rsp.physical_address, rsp.leaf_flags);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        case (want.status)
          ST_OK:         n_ok++;
          ST_NOT_MAPPED: n_unmapped++;
          default:       n_nospace++;
        endcase
        if (rsp.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.physical_address !== want.physical_address) begin
          $error("physical_address mismatch: expected %h, got %h",
                 want.physical_address, rsp.physical_address);
          errors++;
        end
        if (rsp.leaf_flags !== want.leaf_flags) begin
          $error("leaf_flags mismatch: expected %h, got %h", want.leaf_flags, rsp.leaf_flags);
          errors++;
        end
      end
    end
  end

  // covers the post-reset clearing pass as well
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, expected_rsps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_request(OP_TRANSLATE, 39'h0, 44'h0, 8'h00);
    queue_request(OP_MAP, 39'h0, 44'h0, 8'h00);
    queue_request(OP_TRANSLATE, 39'hFFF, 44'hFFF_FFFF_FFFF, 8'hFF);
    queue_request(OP_MAP, 39'h7F_FFFF_FFFF, 44'hFFF_FFFF_FFFF, 8'hFF);
    queue_request(OP_TRANSLATE, 39'h7F_FFFF_FFFF, 44'h0, 8'h00);
    queue_request(OP_TRANSLATE, 39'h1000, 44'h0, 8'h00);
    queue_request(OP_TRANSLATE, 39'h20_0000, 44'h0, 8'h00);
    queue_request(OP_TRANSLATE, 39'h4000_0000, 44'h0, 8'h00);
    queue_request(OP_MAP, 39'hABC, 44'h123_4567_89AB, 8'hA4);
    queue_request(OP_TRANSLATE, 39'h5A5, 44'h0, 8'h00);
    queue_request(OP_MAP, 39'h20_1000, 44'h1, 8'hFE);
    queue_request(OP_TRANSLATE, 39'h20_1FFF, 44'h0, 8'h00);
    queue_request(OP_MAP, 39'h7F_C000_0000, 44'h555_5555_5555, 8'h5A);
    queue_request(OP_MAP, 39'h7F_FFFF_E000, 44'h800_0000_0000, 8'h80);
    queue_request(OP_TRANSLATE, 39'h7F_FFFF_E123, 44'h0, 8'h00);
    queue_request(OP_TRANSLATE, 39'h7F_C000_0000, 44'h0, 8'h00);
    queue_request(OP_TRANSLATE, 39'h7F_C000_1000, 44'h0, 8'h00);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      repeat (RANDOM_PER_PHASE) queue_random_request();
      // wait until every queued request is sent and answered before the next phase
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d map and %0d translate transactions over four idle/stall phases.",
             n_ok + n_unmapped + n_nospace - n_translate, n_translate);
    $display("Results: %0d ok, %0d not mapped, %0d no free table; %0d of %0d tables in use.",
             n_ok, n_unmapped, n_nospace, tables_used, TABLE_COUNT);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tlpt_pkg.sv
rtl/three_level_page_table_store.sv
rtl/tlpt_checker.sv
sim/tb_top.sv
